// ----- hdl/hfcd_pkg.sv -----
// Shared widths, handoff structs and controller states for the half-frame cosine DFT.
package hfcd_pkg;

   localparam int SAMPLE_W = 16;   // audio sample width
   localparam int COEF_W   = 17;   // Q15 cosine, holds +1.0 exactly
   localparam int PROD_W   = SAMPLE_W + COEF_W;
   localparam int ACC_W    = 38;   // 32 products of magnitude up to 2^30, plus sign
   localparam int MAG_W    = 21;   // |acc| >> 15
   localparam int MAG_LSB  = 15;
   localparam int BIN_W    = 6;

   // one sample walking down the cell row
   typedef struct packed {
      logic                       valid;
      logic signed [SAMPLE_W-1:0] sample;
   } sample_beat_type;

   // commands broadcast from the controller to every cell
   typedef struct packed {
      logic load;     // latch magnitudes, clear accumulators and phases
      logic rotate;   // shift magnitude ring one cell toward the output
   } cell_cmd_type;

   typedef enum logic [1:0] {
      ST_FILL,
      ST_SETTLE,
      ST_LOAD,
      ST_SEND
   } ctrl_state_type;

endpackage

// ----- hdl/hfcd_cell.sv -----
// One bin cell: cosine table, phase walker, multiply-accumulate and a slot of the magnitude ring.
module hfcd_cell #(
   parameter int FRAME_SIZE = 64,
   parameter int BIN        = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  hfcd_pkg::cell_cmd_type        cmd,
   input  hfcd_pkg::sample_beat_type     beat_prev,
   output hfcd_pkg::sample_beat_type     beat,
   input  logic [hfcd_pkg::MAG_W-1:0]    nbr_mag,
   output logic [hfcd_pkg::MAG_W-1:0]    mag
);

   localparam int PH_W = $clog2(FRAME_SIZE);
   localparam logic [PH_W:0] STEP = (PH_W + 1)'(BIN);
   localparam logic [PH_W:0] WRAP = (PH_W + 1)'(FRAME_SIZE);
   localparam logic [63:0] Q30_ONE     = 64'd1073741824;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // two Q30 multiplies by x, truncating after each
   function automatic logic [63:0] sq_step(input logic [63:0] t, input logic [63:0] x);
      logic [63:0] p;
      p = (t * x) >> 30;
      return (p * x) >> 30;
   endfunction

   // Q15 cosine of 2*pi*a/FRAME_SIZE, quadrant-folded Taylor series in Q30
   function automatic logic signed [hfcd_pkg::COEF_W-1:0] cos_entry(input int a);
      logic [63:0]        q;
      logic [63:0]        quad;
      logic [63:0]        r;
      logic [63:0]        x;
      logic [63:0]        term;
      logic [63:0]        rnd;
      logic signed [63:0] sum;
      logic               want_sin;
      logic signed [hfcd_pkg::COEF_W-1:0] c;
      q        = 64'(a) * 64'd4;
      quad     = (q / FRAME_SIZE) & 64'd3;
      r        = q % FRAME_SIZE;
      x        = (r * HALF_PI_Q30) / FRAME_SIZE;
      want_sin = quad[0];
      term     = want_sin ? x : Q30_ONE;
      sum      = $signed(term);
      term = sq_step(term, x);
      term = want_sin ? term / 64'd6 : term / 64'd2;
      sum  = sum - $signed(term);
      term = sq_step(term, x);
      term = want_sin ? term / 64'd20 : term / 64'd12;
      sum  = sum + $signed(term);
      term = sq_step(term, x);
      term = want_sin ? term / 64'd42 : term / 64'd30;
      sum  = sum - $signed(term);
      term = sq_step(term, x);
      term = want_sin ? term / 64'd72 : term / 64'd56;
      sum  = sum + $signed(term);
      term = sq_step(term, x);
      term = want_sin ? term / 64'd110 : term / 64'd90;
      sum  = sum - $signed(term);
      term = sq_step(term, x);
      term = want_sin ? term / 64'd156 : term / 64'd132;
      sum  = sum + $signed(term);
      term = sq_step(term, x);
      term = want_sin ? term / 64'd210 : term / 64'd182;
      sum  = sum - $signed(term);
      if (sum < 0) begin
         sum = '0;
      end
      rnd = ($unsigned(sum) + 64'd16384) >> 15;
      c   = $signed(rnd[hfcd_pkg::COEF_W-1:0]);
      return (quad == 64'd1 || quad == 64'd2) ? -c : c;
   endfunction

   logic signed [hfcd_pkg::COEF_W-1:0] rom [FRAME_SIZE];

   for (genvar a = 0; a < FRAME_SIZE; a++) begin : g_rom
      assign rom[a] = cos_entry(a);
   end

   logic [PH_W-1:0]                      phase_ff, phase_in;
   logic [PH_W:0]                        phase_sum;
   logic signed [hfcd_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic                                 prod_v_ff;
   logic signed [hfcd_pkg::ACC_W-1:0]    acc_ff, acc_in;
   logic [hfcd_pkg::ACC_W-1:0]           acc_abs;
   logic [hfcd_pkg::MAG_W-1:0]           mag_ff, mag_in;
   hfcd_pkg::sample_beat_type            beat_ff;

   // phase = t*BIN mod FRAME_SIZE for the sample now in this cell
   always_comb begin
      phase_sum = {1'b0, phase_ff} + STEP;
      if (cmd.load) begin
         phase_in = '0;
      end else if (beat_prev.valid) begin
         phase_in = (phase_sum >= WRAP) ? PH_W'(phase_sum - WRAP) : PH_W'(phase_sum);
      end else begin
         phase_in = phase_ff;
      end
   end

   assign prod_in = beat_prev.sample * rom[phase_ff];

   always_comb begin
      if (cmd.load) begin
         acc_in = '0;
      end else if (prod_v_ff) begin
         acc_in = acc_ff + hfcd_pkg::ACC_W'(prod_ff);
      end else begin
         acc_in = acc_ff;
      end
   end

   assign acc_abs = acc_ff[hfcd_pkg::ACC_W-1] ? $unsigned(-acc_ff) : $unsigned(acc_ff);

   always_comb begin
      if (cmd.load) begin
         mag_in = acc_abs[hfcd_pkg::MAG_LSB +: hfcd_pkg::MAG_W];
      end else if (cmd.rotate) begin
         mag_in = nbr_mag;
      end else begin
         mag_in = mag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= '0;
         prod_v_ff     <= 1'b0;
         acc_ff        <= '0;
         beat_ff.valid <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         prod_v_ff     <= beat_prev.valid;
         acc_ff        <= acc_in;
         beat_ff.valid <= beat_prev.valid;
      end
      prod_ff        <= prod_in;
      beat_ff.sample <= beat_prev.sample;
      mag_ff         <= mag_in;
   end

   assign beat = beat_ff;
   assign mag  = mag_ff;

endmodule

// ----- hdl/hfcd_ctrl.sv -----
// Frame controller: fill counter, result counter, bin numbering and cell commands.
module hfcd_ctrl #(
   parameter int FRAME_SIZE = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   output logic                          store_en,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [hfcd_pkg::BIN_W-1:0]    bin_index,
   output logic                          frame_end,
   output hfcd_pkg::cell_cmd_type        cmd
);

   localparam int HALF  = FRAME_SIZE / 2;
   localparam int CNT_W = $clog2(FRAME_SIZE);
   localparam logic [CNT_W-1:0] HALF_CNT  = CNT_W'(HALF);
   localparam logic [CNT_W-1:0] LAST_FILL = CNT_W'(FRAME_SIZE - 1);
   localparam logic [CNT_W-1:0] LAST_OUT  = CNT_W'(2 * HALF - 1);
   localparam logic [CNT_W:0]   MIRROR    = (CNT_W + 1)'(FRAME_SIZE - 1 + HALF);

   hfcd_pkg::ctrl_state_type state_ff, state_in;
   logic [CNT_W-1:0]         fill_ff, fill_in;
   logic [CNT_W-1:0]         out_cnt_ff, out_cnt_in;
   logic [CNT_W:0]           bin_wide;
   logic                     req_xfer;
   logic                     rsp_xfer;

   assign req_xfer = req_tvalid && req_tready;
   assign rsp_xfer = rsp_tvalid && rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hfcd_pkg::ST_FILL: begin
            if (req_xfer && fill_ff == LAST_FILL) begin
               state_in = hfcd_pkg::ST_SETTLE;
            end
         end
         hfcd_pkg::ST_SETTLE: begin
            state_in = hfcd_pkg::ST_LOAD;
         end
         hfcd_pkg::ST_LOAD: begin
            state_in = hfcd_pkg::ST_SEND;
         end
         hfcd_pkg::ST_SEND: begin
            if (rsp_xfer && out_cnt_ff == LAST_OUT) begin
               state_in = hfcd_pkg::ST_FILL;
            end
         end
         default: begin
            state_in = hfcd_pkg::ST_FILL;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      cmd.load   = 1'b0;
      unique case (state_ff)
         hfcd_pkg::ST_FILL:   req_tready = 1'b1;
         hfcd_pkg::ST_SETTLE: ;
         hfcd_pkg::ST_LOAD:   cmd.load   = 1'b1;
         hfcd_pkg::ST_SEND:   rsp_tvalid = 1'b1;
         default: ;
      endcase
      cmd.rotate = rsp_xfer;
   end

   assign store_en = req_xfer && (fill_ff < HALF_CNT);

   always_comb begin
      fill_in = fill_ff;
      if (req_xfer) begin
         fill_in = (fill_ff == LAST_FILL) ? '0 : fill_ff + 1'b1;
      end
      out_cnt_in = out_cnt_ff;
      if (cmd.load) begin
         out_cnt_in = '0;
      end else if (rsp_xfer) begin
         out_cnt_in = out_cnt_ff + 1'b1;
      end
   end

   // first pass numbers bins 0..H-1, second pass mirrors them from the top
   assign bin_wide  = (out_cnt_ff < HALF_CNT) ? {1'b0, out_cnt_ff} : MIRROR - {1'b0, out_cnt_ff};
   assign bin_index = hfcd_pkg::BIN_W'(bin_wide);
   assign frame_end = (out_cnt_ff == LAST_OUT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= hfcd_pkg::ST_FILL;
         fill_ff    <= '0;
         out_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         out_cnt_ff <= out_cnt_in;
      end
   end

   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load && cmd.rotate))
      else $error("load and rotate in the same cycle");

   a_frame_close: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && fill_ff == LAST_FILL) |=> !req_tready ##1 cmd.load)
      else $error("final item did not lead to a load");

   a_load_start: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (rsp_tvalid && out_cnt_ff == '0))
      else $error("result burst did not start at count zero");

   a_burst_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && frame_end) |=> (req_tready && !rsp_tvalid && fill_ff == '0))
      else $error("frame did not return to fill after last result");

endmodule

// ----- hdl/half_frame_cosine_dft.sv -----
// Top level of the half-frame cosine DFT: channel select, sample feed and the row of bin cells.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+-------------------------------------------
//  req     | in  | req_tvalid/req_tready  | req_tdata: left_sample, right_sample
//  rsp     | out | rsp_tvalid/rsp_tready  | rsp_tdata: bin_index, magnitude; rsp_tlast
//  csr     | in  | csr_valid/csr_ready    | csr_wdata: channel_select
//
// Samples are taken one per cycle while a frame fills; each stored sample walks the cell
// row one cell per cycle, every cell doing one MAC for its own bin.
// After the last item of a frame, the controller steps through SETTLE and LOAD while the row drains
// and magnitudes latch, then FRAME_SIZE/2*2 results leave one per cycle while rsp_tready is high.
// req_tready is low from the last item until the last result transfer; rsp_tready low just holds
// the ring, since the magnitude ring shifts only on a result transfer.
// Reset clears the fill count, the accumulators and channel_select (left).
module half_frame_cosine_dft #(
   parameter int FRAME_SIZE = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // [15:0] left_sample, [31:16] right_sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // [5:0] bin_index, [26:6] magnitude, [31:27] zero
   output logic        rsp_tlast,    // frame_end
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_wdata     // channel_select
);

   localparam int HALF = FRAME_SIZE / 2;

   logic                              chan_ff, chan_in;
   logic                              store_en;
   hfcd_pkg::sample_beat_type         feed_ff;
   hfcd_pkg::cell_cmd_type            cmd;
   hfcd_pkg::sample_beat_type         beats [HALF+1];
   logic [hfcd_pkg::MAG_W-1:0]        mags  [HALF];
   logic [hfcd_pkg::BIN_W-1:0]        bin_index;

   // config: always ready, takes effect for the next item
   assign csr_ready = 1'b1;
   assign chan_in   = (csr_valid && csr_ready) ? csr_wdata : chan_ff;

   // only first-half samples enter the row
   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff       <= 1'b0;
         feed_ff.valid <= 1'b0;
      end else begin
         chan_ff       <= chan_in;
         feed_ff.valid <= store_en;
      end
      feed_ff.sample <= chan_ff ? $signed(req_tdata[31:16]) : $signed(req_tdata[15:0]);
   end

   hfcd_ctrl #(
      .FRAME_SIZE (FRAME_SIZE)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .store_en   (store_en),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .bin_index  (bin_index),
      .frame_end  (rsp_tlast),
      .cmd        (cmd)
   );

   assign beats[0] = feed_ff;

   // cell k accumulates bin k; magnitudes rotate toward cell 0 on each result transfer
   for (genvar k = 0; k < HALF; k++) begin : g_cell
      hfcd_cell #(
         .FRAME_SIZE (FRAME_SIZE),
         .BIN        (k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .beat_prev (beats[k]),
         .beat      (beats[k+1]),
         .nbr_mag   (mags[(k + 1) % HALF]),
         .mag       (mags[k])
      );
   end

   assign rsp_tdata = {5'b0, mags[0], bin_index};

   // the row must be empty whenever results are being sent
   a_row_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !beats[HALF].valid)
      else $error("sample still in flight during result burst");

   a_no_feed_in_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !feed_ff.valid)
      else $error("sample fed while results pending");

endmodule

// ----- dv/tb_half_frame_cosine_dft.sv -----
// Self-checking testbench for the half-frame cosine DFT: stream driver, result monitor, predictor.
module tb_half_frame_cosine_dft;

   localparam int FRAME_SIZE = 64;
   localparam int HALF = FRAME_SIZE / 2;
   // a stored sample walks 32 cells, then the controller settles and loads; leave margin before csr writes
   localparam int SETTLE_CYCLES = 48;
   localparam int HOLD_CYCLES = 400;          // long receiver hold-off
   localparam int CYCLE_LIMIT = 200000;
   localparam int SHOWN_MISMATCHES = 10;
   localparam int MID_SWITCH = 10;            // pairs taken before the channel switch
   localparam longint unsigned Q30_ONE = 64'd1073741824;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   // channel_select codes
   localparam logic CHAN_LEFT = 1'b0;
   localparam logic CHAN_RIGHT = 1'b1;

   // sample value mixes for random frames
   typedef enum int {
      MIX_FULL,
      MIX_EXTREME,
      MIX_TINY,
      MIX_ANY
   } sample_mix_type;

   typedef struct packed {
      logic [hfcd_pkg::BIN_W-1:0] bin;
      logic [hfcd_pkg::MAG_W-1:0] mag;
      logic                       last;
   } bin_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_wdata = 1'b0;

   // stimulus side
   logic [31:0] pending_pairs[$];   // {right, left} pairs waiting for the driver
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   logic        hold_go = 1'b0;     // set once by the sequence, starts the hold-off
   int          hold_count = 0;
   logic        holding;

   // predictor state, owned by the monitor process
   logic                                 channel_sel = CHAN_LEFT;
   logic signed [hfcd_pkg::SAMPLE_W-1:0] first_half[0:HALF-1];
   int                                   fill_count = 0;
   bin_result_type                       expected_bins[$];

   int mismatches = 0;
   int cycle_count = 0;

   half_frame_cosine_dft #(.FRAME_SIZE(FRAME_SIZE)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   // Taylor series of cos or sin in Q30, truncating after every step
   function automatic longint taylor_q30(input longint unsigned x, input bit want_sin);
      longint unsigned term;
      longint unsigned n;
      longint          sum;
      term = want_sin ? x : Q30_ONE;
      sum = longint'(term);
      n = want_sin ? 64'd1 : 64'd0;
      for (int i = 1; i <= 7; i++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         term = term / ((n + 64'd1) * (n + 64'd2));
         n += 64'd2;
         if (i % 2 == 1) begin
            sum -= longint'(term);
         end else begin
            sum += longint'(term);
         end
      end
      return sum;
   endfunction

   // Q15 cosine of 2*pi*m/FRAME_SIZE, quadrant folded onto a first-quadrant series
   function automatic int cosine_q15(input int m);
      int              a;
      int              q;
      int              quad;
      int              r;
      longint unsigned x;
      longint          v;
      int              mag;
      a = m % FRAME_SIZE;
      q = 4 * a;
      quad = (q / FRAME_SIZE) & 3;
      r = q % FRAME_SIZE;
      x = (longint'(r) * HALF_PI_Q30) / FRAME_SIZE;
      v = taylor_q30(x, (quad & 1) != 0);
      if (v < 0) begin
         v = 0;
      end
      mag = int'((v + 16384) >>> 15);
      return (quad == 1 || quad == 2) ? -mag : mag;
   endfunction

   // take one accepted pair; on the frame's last item queue all bin results
   task automatic absorb_pair(input logic [31:0] pair);
      logic [hfcd_pkg::MAG_W-1:0] mags[0:HALF-1];
      longint                     acc;
      bin_result_type             res;
      if (fill_count < HALF) begin
         first_half[fill_count] = (channel_sel == CHAN_RIGHT) ? pair[31:16] : pair[15:0];
      end
      if (fill_count + 1 < FRAME_SIZE) begin
         fill_count++;
      end else begin
         fill_count = 0;
         for (int k = 0; k < HALF; k++) begin
            acc = 0;
            for (int t = 0; t < HALF; t++) begin
               acc += longint'(first_half[t]) * longint'(cosine_q15(t * k));
            end
            if (acc < 0) begin
               acc = -acc;
            end
            mags[k] = hfcd_pkg::MAG_W'(acc >>> hfcd_pkg::MAG_LSB);
         end
         // ascending bins first, then the mirrored copy ending in the frame mark
         for (int k = 0; k < HALF; k++) begin
            res.bin = hfcd_pkg::BIN_W'(k);
            res.mag = mags[k];
            res.last = 1'b0;
            expected_bins.push_back(res);
         end
         for (int k = 0; k < HALF; k++) begin
            res.bin = hfcd_pkg::BIN_W'(FRAME_SIZE - 1 - k);
            res.mag = mags[k];
            res.last = (k == HALF - 1);
            expected_bins.push_back(res);
         end
      end
   endtask

   task automatic flag_mismatch(input string what, input longint want, input longint got);
      mismatches++;
      if (mismatches <= SHOWN_MISMATCHES) begin
         $display("mismatch at cycle %0d: %s expected %0d got %0d", cycle_count, what, want, got);
      end
   endtask

   // ---------------------------------------------------------------- driver

   // req side: a new pair goes out only once the current one has transferred
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata <= pending_pairs.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // hold-off counter, runs once after the sequence raises hold_go
   always @(posedge clock) begin
      if (hold_go && hold_count < HOLD_CYCLES) begin
         hold_count <= hold_count + 1;
      end
   end
   assign holding = hold_go && hold_count < HOLD_CYCLES;

   // rsp side back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !holding && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin : monitor
      bin_result_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            channel_sel <= csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            absorb_pair(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_bins.size() == 0) begin
               flag_mismatch("unexpected result, tdata", 0, rsp_tdata);
            end else begin
               want = expected_bins.pop_front();
               if (rsp_tdata[hfcd_pkg::BIN_W-1:0] !== want.bin) begin
                  flag_mismatch("bin_index", want.bin, rsp_tdata[hfcd_pkg::BIN_W-1:0]);
               end
               if (rsp_tdata[hfcd_pkg::BIN_W +: hfcd_pkg::MAG_W] !== want.mag) begin
                  flag_mismatch($sformatf("magnitude of bin %0d", want.bin), want.mag,
                                rsp_tdata[hfcd_pkg::BIN_W +: hfcd_pkg::MAG_W]);
               end
               if (rsp_tdata[31:hfcd_pkg::BIN_W+hfcd_pkg::MAG_W] !== '0) begin
                  flag_mismatch("tdata pad bits", 0,
                                rsp_tdata[31:hfcd_pkg::BIN_W+hfcd_pkg::MAG_W]);
               end
               if (rsp_tlast !== want.last) begin
                  flag_mismatch($sformatf("tlast of bin %0d", want.bin), want.last, rsp_tlast);
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence

   function automatic logic [31:0] make_pair(input logic [15:0] left, input logic [15:0] right);
      return {right, left};
   endfunction

   function automatic logic [15:0] pick_sample(input sample_mix_type mix);
      logic [15:0] extremes[5];
      sample_mix_type m;
      extremes = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};
      m = (mix == MIX_ANY) ? sample_mix_type'($urandom_range(2)) : mix;
      case (m)
         MIX_EXTREME: return extremes[$urandom_range(4)];
         MIX_TINY:    return 16'($signed($urandom_range(16)) - 8);
         default:     return 16'($urandom);
      endcase
   endfunction

   task automatic offer_random(input int count);
      sample_mix_type mix;
      mix = sample_mix_type'($urandom_range(3));
      for (int i = 0; i < count; i++) begin
         pending_pairs.push_back(make_pair(pick_sample(mix), pick_sample(mix)));
      end
   endtask

   // idle point: every pair transferred, every result back, the cell row drained;
   // checked at the falling edge so that the driver's updates have landed
   task automatic wait_quiet();
      do @(negedge clock);
      while (pending_pairs.size() != 0 || req_tvalid || expected_bins.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_channel(input logic value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // no idling: full-scale negative left channel gives bin 0 its largest magnitude;
      // the rsp hold-off keeps the burst waiting while the next frame's pairs back up
      write_channel(CHAN_LEFT);
      hold_go = 1'b1;
      for (int t = 0; t < FRAME_SIZE; t++) begin
         pending_pairs.push_back(t < HALF ? make_pair(16'h8000, 16'h7FFF)
                                          : make_pair(16'($urandom), 16'($urandom)));
      end
      for (int t = 0; t < MID_SWITCH; t++) begin
         pending_pairs.push_back(make_pair(16'h0001, 16'hFFFF));
      end
      wait_quiet();

      // channel switched in the middle of the first half; each pair uses the setting it saw
      write_channel(CHAN_RIGHT);
      send_idle_pct = 47;
      offer_random(HALF - MID_SWITCH);
      wait_quiet();

      // second half with both sides idling, then receiver stalls for the rest of the burst
      send_idle_pct = 30;
      recv_stall_pct = 30;
      offer_random(HALF);
      do @(negedge clock);
      while (pending_pairs.size() != 0 || req_tvalid || expected_bins.size() > HALF);
      send_idle_pct = 0;
      recv_stall_pct = 47;
      wait_quiet();

      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hdl/hfcd_pkg.sv
hdl/hfcd_cell.sv
hdl/hfcd_ctrl.sv
hdl/half_frame_cosine_dft.sv
dv/tb_half_frame_cosine_dft.sv
